>>> src/ple_pkg.sv
package ple_pkg;

  localparam int MAX_SEGMENTS_DEF = 16;
  localparam int LEVEL_BITS_DEF   = 32;

  localparam int LEVEL_W   = 32;
  localparam int SECONDS_W = 24;
  localparam int INDEX_W   = 5;
  localparam int COUNT_W   = 5;
  localparam int ENVLEN_W  = 21;
  localparam int RATE_W    = 18;
  localparam int FRAME_W   = 20;
  localparam int TRANS_W   = 21;
  localparam int FRAMES_W  = 26;
  localparam int SLOPE_W   = 47;
  localparam int DIVIDEND_W = 49;
  localparam int MUL_A_W   = 24;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 21;

  localparam logic [TRANS_W-1:0] FRAMES_CAP = TRANS_W'(1) << 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEGMENT_COUNT   = 2'd0,
    CFG_ENVELOPE_FRAMES = 2'd1,
    CFG_SAMPLE_RATE     = 2'd2,
    CFG_HOLD_MODE       = 2'd3
  } cfg_index_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_BEG_MUL = 8'b0000_0010,
    ST_BEG_CHK = 8'b0000_0100,
    ST_DIV     = 8'b0000_1000,
    ST_RAMP_A  = 8'b0001_0000,
    ST_RAMP_B  = 8'b0010_0000,
    ST_RAMP_C  = 8'b0100_0000,
    ST_OUT     = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic                    start;
    logic [DIVIDEND_W-1:0]   dividend;
    logic [FRAMES_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic [DIVIDEND_W-1:0]   quotient;
  } div_rsp_t;

endpackage

>>> src/ple_if.sv
interface ple_req_if import ple_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [INDEX_W-1:0]   point_index;
  logic signed [LEVEL_W-1:0] level;
  logic [SECONDS_W-1:0] segment_seconds;

  modport source (output valid, operation, point_index, level, segment_seconds, input ready);
  modport sink   (input valid, operation, point_index, level, segment_seconds, output ready);
endinterface

interface ple_rsp_if import ple_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [LEVEL_W-1:0] sample;
  logic                 frame_last;

  modport source (output valid, sample, frame_last, input ready);
  modport sink   (input valid, sample, frame_last, output ready);
endinterface

>>> src/ple_mul.sv
module ple_mul import ple_pkg::*; (
  input  logic               clk,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

>>> src/ple_div.sv
module ple_div import ple_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [CNT_W-1:0]      count;
  logic [FRAMES_W-1:0]   divisor;
  logic [FRAMES_W:0]     rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [FRAMES_W:0]     rem_sh;
  logic                  fits;

  assign rem_sh = {rem[FRAMES_W-1:0], quo[DIVIDEND_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      count    <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy     <= 1'b0;
          rsp.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      rem     <= '0;
      quo     <= req.dividend;
    end else if (busy) begin
      rem <= fits ? rem_sh - {1'b0, divisor} : rem_sh;
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

  assign rsp.quotient = quo;

endmodule

>>> src/piecewise_linear_envelope.sv
// Breakpoint envelope generator. Write requests (operation 0) store entry point_index of the
// breakpoint table: entry 0 is the start level, entry k the end level and Q8.16 length in
// seconds of segment k-1. Each tick request (operation 1) returns one Q16.16 sample, with
// frame_last high on the final frame of a pass. A tick inside a segment steps through RAMP_A,
// RAMP_B, RAMP_C and OUT, using the shared 24x32 multiplier twice for the ramp product. A tick
// that starts a segment steps through BEG_MUL and BEG_CHK per skipped empty segment, then the
// frame-count multiply and bit-serial slope division; the block accepts nothing meanwhile.
// Configuration must be written only while no tick is in flight; the block does not enforce it.
module piecewise_linear_envelope import ple_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int LEVEL_BITS   = LEVEL_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  ple_req_if.sink              req,
  ple_rsp_if.source            rsp,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int SW = $clog2(MAX_SEGMENTS + 1);
  localparam int LW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int VW = 50;
  localparam logic signed [VW-1:0] V_HI = (VW'(1) <<< (LEVEL_BITS - 1)) - VW'(1);
  localparam logic signed [VW-1:0] V_LO = -V_HI - VW'(1);

  logic [COUNT_W-1:0]  segment_count;
  logic [ENVLEN_W-1:0] envelope_frames;
  logic [RATE_W-1:0]   sample_rate;
  logic                hold_mode;

  logic signed [LEVEL_W-1:0] level_table [MAX_SEGMENTS+1];
  logic [SECONDS_W-1:0]      length_table [MAX_SEGMENTS];

  state_t state;
  logic                      post;
  logic [FRAME_W-1:0]        frame_counter;
  logic [SW-1:0]             segment_number;
  logic [SW-1:0]             seg;
  logic [TRANS_W-1:0]        transition_counter;
  logic [TRANS_W-1:0]        transition_frames;
  logic                      slope_neg;
  logic [SLOPE_W-1:0]        slope_mag;
  logic signed [LEVEL_W-1:0] segment_start_level;
  logic                      diff_neg;
  logic [FRAMES_W-1:0]       frames;
  logic [MUL_P_W-1:0]        acc;
  logic [MUL_P_W-1:0]        offset;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic [SW-1:0]             lim;
  logic [ENVLEN_W-1:0]       env_len;
  logic                      last;
  logic                      in_seg;
  logic [FRAMES_W-1:0]       p_frames;
  logic signed [LEVEL_W:0]   diff;
  logic [LEVEL_W:0]          diff_mag;
  logic signed [VW-1:0]      value;
  logic signed [VW-1:0]      clamped;
  logic [TRANS_W-1:0]        tc_inc;
  logic [INDEX_W-1:0]        widx;

  assign lim = (32'(segment_count) > 32'(MAX_SEGMENTS)) ? SW'(MAX_SEGMENTS)
                                                          : SW'(segment_count);
  assign env_len = (envelope_frames == '0) ? ENVLEN_W'(1) :
                   (envelope_frames > ENVLEN_W'(FRAMES_CAP)) ? ENVLEN_W'(FRAMES_CAP) :
                   envelope_frames;
  assign last     = ENVLEN_W'(frame_counter) >= env_len - ENVLEN_W'(1);
  assign in_seg   = segment_number < lim;
  assign p_frames = mul_p[FRAMES_W+15:16];
  assign diff     = (LEVEL_W+1)'(level_table[seg + SW'(1)]) - (LEVEL_W+1)'(segment_start_level);
  assign diff_mag = diff[LEVEL_W] ? (LEVEL_W+1)'(-diff) : (LEVEL_W+1)'(diff);
  assign tc_inc   = transition_counter + TRANS_W'(1);
  assign widx     = req.point_index;

  always_comb begin
    if (hold_mode) begin
      value = VW'(level_table[0]);
    end else if (in_seg) begin
      value = slope_neg ? VW'(segment_start_level) - VW'(offset)
                        : VW'(segment_start_level) + VW'(offset);
    end else begin
      value = VW'(segment_start_level);
    end
    if (value > V_HI) clamped = V_HI;
    else if (value < V_LO) clamped = V_LO;
    else clamped = value;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_BEG_MUL: begin
        mul_a = MUL_A_W'(length_table[seg[LW-1:0]]);
        mul_b = MUL_B_W'(sample_rate);
      end
      ST_RAMP_A: begin
        mul_a = MUL_A_W'(transition_counter);
        mul_b = MUL_B_W'(slope_mag[SLOPE_W-1:32]);
      end
      ST_RAMP_B: begin
        mul_a = MUL_A_W'(transition_counter);
        mul_b = slope_mag[31:0];
      end
      default: ;
    endcase
  end

  ple_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));
  ple_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  assign div_req.start    = (state == ST_BEG_CHK) && (p_frames != '0) && (seg < lim);
  assign div_req.dividend = {diff_mag, 16'd0};
  assign div_req.divisor  = p_frames;

  assign req.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count   <= '0;
      envelope_frames <= ENVLEN_W'(1024);
      sample_rate     <= RATE_W'(44100);
      hold_mode       <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SEGMENT_COUNT:   segment_count   <= cfg_data[COUNT_W-1:0];
        CFG_ENVELOPE_FRAMES: envelope_frames <= cfg_data[ENVLEN_W-1:0];
        CFG_SAMPLE_RATE:     sample_rate     <= cfg_data[RATE_W-1:0];
        CFG_HOLD_MODE:       hold_mode       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready && req.operation == OP_WRITE &&
        32'(widx) <= 32'(MAX_SEGMENTS)) begin
      level_table[SW'(widx)] <= req.level;
      if (widx != '0) length_table[LW'(widx - INDEX_W'(1))] <= req.segment_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      post                <= 1'b0;
      frame_counter       <= '0;
      segment_number      <= '0;
      seg                 <= '0;
      transition_counter  <= '0;
      transition_frames   <= '0;
      slope_neg           <= 1'b0;
      slope_mag           <= '0;
      segment_start_level <= '0;
      rsp.valid           <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != ST_OUT) rsp.valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (req.valid && req.operation == OP_TICK) begin
            if (frame_counter == '0) begin
              segment_start_level <= level_table[0];
              seg   <= '0;
              post  <= 1'b0;
              state <= ST_BEG_MUL;
            end else begin
              state <= ST_RAMP_A;
            end
          end
        end
        ST_BEG_MUL: begin
          if (seg < lim) begin
            state <= ST_BEG_CHK;
          end else begin
            segment_number     <= lim;
            transition_counter <= '0;
            transition_frames  <= '0;
            slope_neg          <= 1'b0;
            slope_mag          <= '0;
            state <= post ? ST_IDLE : ST_RAMP_A;
          end
        end
        ST_BEG_CHK: begin
          if (p_frames == '0) begin
            segment_start_level <= level_table[seg + SW'(1)];
            seg   <= seg + SW'(1);
            state <= ST_BEG_MUL;
          end else begin
            frames   <= p_frames;
            diff_neg <= diff[LEVEL_W];
            state    <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            slope_neg <= diff_neg;
            slope_mag <= (div_rsp.quotient[DIVIDEND_W-1:SLOPE_W] != '0) ? '1
                         : div_rsp.quotient[SLOPE_W-1:0];
            transition_frames  <= (FRAMES_W'(FRAMES_CAP) < frames) ? FRAMES_CAP
                                  : TRANS_W'(frames);
            transition_counter <= '0;
            segment_number     <= seg;
            state <= post ? ST_IDLE : ST_RAMP_A;
          end
        end
        ST_RAMP_A: begin
          state <= in_seg ? ST_RAMP_B : ST_OUT;
        end
        ST_RAMP_B: begin
          acc   <= mul_p;
          state <= ST_RAMP_C;
        end
        ST_RAMP_C: begin
          offset <= acc + MUL_P_W'(mul_p[MUL_P_W-1:32]);
          state  <= ST_OUT;
        end
        ST_OUT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid      <= 1'b1;
            rsp.sample     <= clamped[LEVEL_W-1:0];
            rsp.frame_last <= last;
            frame_counter  <= last ? '0 : frame_counter + FRAME_W'(1);
            if (in_seg) begin
              transition_counter <= tc_inc;
              if (tc_inc >= transition_frames) begin
                segment_start_level <= level_table[segment_number + SW'(1)];
                seg   <= segment_number + SW'(1);
                post  <= 1'b1;
                state <= ST_BEG_MUL;
              end else begin
                state <= ST_IDLE;
              end
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
